### design/elbt_pkg.sv
// shared types, codes and constants of the eight-lane led bit transposer
`default_nettype none

package elbt_pkg;

   localparam int PIXEL_DEPTH_DEF = 8192;
   localparam int PIN_COUNT       = 8;
   localparam int VAL_W           = 16;
   localparam int GRB_W           = 24;

   localparam logic [1:0] OP_WRITE_PIXEL = 2'd0;
   localparam logic [1:0] OP_WRITE_GAMMA = 2'd1;
   localparam logic [1:0] OP_EMIT        = 2'd2;

   localparam logic [1:0] CSR_STRIP_LENGTH = 2'd0;
   localparam logic [1:0] CSR_LED_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_SERPENTINE   = 2'd2;
   localparam logic [1:0] CSR_SYNC_DELAY   = 2'd3;

   localparam logic [1:0] COMP_RED   = 2'd0;
   localparam logic [1:0] COMP_GREEN = 2'd1;
   localparam logic [1:0] COMP_BLUE  = 2'd2;

   localparam logic [7:0] SYNC_CHAR = 8'h2A;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SETUP,
      ST_HEADER,
      ST_GATHER,
      ST_GAMMA,
      ST_SEND
   } st_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic        panel;
      logic [11:0] pixel_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  gamma_index;
      logic [7:0]  gamma_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       frame_done;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             panel;
      logic [VAL_W-1:0] value;
   } addr_req_type;

endpackage

`default_nettype wire

### design/eight_lane_led_bit_transposer.sv
// Eight-lane LED bit transposer, top level. One item at a time: busy is high from
// acceptance until the item's work is done; a gamma write is done in the cycle in
// which it is taken and leaves busy low. A pixel write waits for its address to pass
// the address unit's modulo stages. An emit item starts with the header bytes when it
// opens a frame, then makes eight pixel reads through the single port of the pixel
// store, then 24 gamma lookups through the single read port of the gamma table, then
// 24 output bytes, one per cycle. Results appear on rsp_item for exactly one cycle each
// while rsp_strobe is high; the receiver must take every one, there is no back pressure.
// The last byte of an emit item is shown in the first cycle in which busy is low. The csr
// port is always ready; write it only while busy is low and no results are pending.
`default_nettype none

module eight_lane_led_bit_transposer #(
   parameter int PIXEL_DEPTH = elbt_pkg::PIXEL_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire elbt_pkg::req_type req_item,
   output logic                   rsp_strobe,
   output elbt_pkg::rsp_type      rsp_item,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   localparam int AW    = $clog2(PIXEL_DEPTH);
   localparam int VW    = elbt_pkg::VAL_W;
   localparam int GW    = elbt_pkg::GRB_W;
   localparam int PINS  = elbt_pkg::PIN_COUNT;
   localparam int PIN_W = $clog2(PINS);
   localparam int CNT_W = $clog2(PINS + 1);
   localparam int BIT_W = $clog2(GW);

   elbt_pkg::st_type state_ff, state_in;

   logic [10:0] strip_length_ff, strip_length_in;
   logic [6:0]  led_height_ff, led_height_in;
   logic        serp_ff, serp_in;
   logic [15:0] sync_delay_ff, sync_delay_in;

   logic [10:0] width_ff, width_in;
   logic [3:0]  spp_ff, spp_in;
   logic [5:0]  half_h_ff, half_h_in;
   logic [6:0]  height_c;

   logic [2:0]  strip_row_ff, strip_row_in;
   logic [9:0]  column_step_ff, column_step_in;

   logic [15:0] dmax_ff, dmax_in;
   logic [9:0]  x_ff, x_in;
   logic [6:0]  row_ff, row_in;
   logic        frame_end_ff, frame_end_in;
   logic [1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic [CNT_W-1:0] collect_cnt_ff, collect_cnt_in;
   logic [16:0] idx_a_ff, idx_a_in;
   logic        va_ff, va_in;
   elbt_pkg::addr_req_type areq_ff, areq_in;
   logic        rvalid_ff, rvalid_in;
   logic [GW-1:0] wdata_ff, wdata_in;
   logic [GW-1:0] pix_sr_ff [PINS];
   logic [GW-1:0] pix_sr_in [PINS];
   logic [GW-1:0] grb_ff [PINS];
   logic [GW-1:0] grb_in [PINS];
   logic [PIN_W-1:0] gpin_ff, gpin_in;
   logic [1:0]  gcomp_ff, gcomp_in;
   logic        gdone_ff, gdone_in;
   logic        gv_ff, gv_in;
   logic [PIN_W-1:0] gtpin_ff, gtpin_in;
   logic [1:0]  gtcomp_ff, gtcomp_in;
   logic [BIT_W-1:0] send_cnt_ff, send_cnt_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   elbt_pkg::rsp_type rsp_item_ff, rsp_item_in;

   logic        accept;
   logic        pos_wrap;
   logic [2:0]  pos_row;
   logic [9:0]  pos_col;
   logic        pos_header;
   logic [9:0]  pos_x;
   logic [10:0] col_inc;
   logic [3:0]  row_inc;
   logic [2:0]  next_row;
   logic [9:0]  next_col;
   logic        next_fend;

   logic          addr_vld;
   logic [AW-1:0] pm_addr;
   logic          pm_we;
   logic [GW-1:0] pm_rdata;
   logic          gm_we;
   logic [7:0]    gm_raddr;
   logic [7:0]    gm_rdata;
   logic [GW-1:0] gsel;

   assign accept    = start && !busy;
   assign busy      = (state_ff != elbt_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // config registers and clamped geometry
   always_comb begin
      strip_length_in = strip_length_ff;
      led_height_in   = led_height_ff;
      serp_in         = serp_ff;
      sync_delay_in   = sync_delay_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            elbt_pkg::CSR_STRIP_LENGTH: strip_length_in = csr_wdata[10:0];
            elbt_pkg::CSR_LED_HEIGHT:   led_height_in   = csr_wdata[6:0];
            elbt_pkg::CSR_SERPENTINE:   serp_in         = csr_wdata[0];
            elbt_pkg::CSR_SYNC_DELAY:   sync_delay_in   = csr_wdata;
            default: ;
         endcase
      end
      if (strip_length_ff == 11'd0) begin
         width_in = 11'd1;
      end else if (strip_length_ff > 11'd1024) begin
         width_in = 11'd1024;
      end else begin
         width_in = strip_length_ff;
      end
      if (led_height_ff < 7'd8) begin
         height_c = 7'd8;
      end else if (led_height_ff > 7'd64) begin
         height_c = 7'd64;
      end else begin
         height_c = led_height_ff;
      end
      spp_in    = 4'(height_c >> 3);
      half_h_in = 6'(height_c >> 1);
   end

   // slot position for the next emit
   always_comb begin
      pos_wrap = ({1'b0, strip_row_ff} >= spp_ff) || ({1'b0, column_step_ff} >= width_ff);
      pos_row  = pos_wrap ? 3'd0 : strip_row_ff;
      pos_col  = pos_wrap ? 10'd0 : column_step_ff;
      pos_header = (pos_row == 3'd0) && (pos_col == 10'd0);
      pos_x = (pos_row[0] ^ serp_ff) ? pos_col : 10'(width_ff - 11'd1 - {1'b0, pos_col});
      col_inc = {1'b0, pos_col} + 11'd1;
      row_inc = {1'b0, pos_row} + 4'd1;
      next_fend = 1'b0;
      if (col_inc >= width_ff) begin
         next_col = 10'd0;
         if (row_inc >= spp_ff) begin
            next_row  = 3'd0;
            next_fend = 1'b1;
         end else begin
            next_row = row_inc[2:0];
         end
      end else begin
         next_col = col_inc[9:0];
         next_row = pos_row;
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      strip_row_in   = strip_row_ff;
      column_step_in = column_step_ff;
      dmax_in        = dmax_ff;
      x_in           = x_ff;
      row_in         = row_ff;
      frame_end_in   = frame_end_ff;
      hdr_cnt_in     = hdr_cnt_ff;
      issue_cnt_in   = issue_cnt_ff;
      collect_cnt_in = collect_cnt_ff;
      gpin_in        = gpin_ff;
      gcomp_in       = gcomp_ff;
      gdone_in       = gdone_ff;
      send_cnt_in    = send_cnt_ff;
      wdata_in       = wdata_ff;
      va_in          = 1'b0;
      gv_in          = 1'b0;
      rsp_strobe_in  = 1'b0;
      rsp_item_in    = rsp_item_ff;
      idx_a_in       = 17'(x_ff) + 17'(row_ff) * 17'(width_ff);
      gtpin_in       = gpin_ff;
      gtcomp_in      = gcomp_ff;
      rvalid_in      = addr_vld && (state_ff == elbt_pkg::ST_GATHER);

      // second gather stage: split into panel and offset
      areq_in = '0;
      if (va_ff) begin
         areq_in.valid = 1'b1;
         if (idx_a_ff >= {1'b0, dmax_ff}) begin
            areq_in.panel = 1'b1;
            areq_in.value = VW'(idx_a_ff - {1'b0, dmax_ff});
         end else begin
            areq_in.panel = 1'b0;
            areq_in.value = VW'(idx_a_ff);
         end
      end

      unique case (state_ff)
         elbt_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_item.operation)
                  elbt_pkg::OP_WRITE_PIXEL: begin
                     areq_in.valid = 1'b1;
                     areq_in.panel = req_item.panel;
                     areq_in.value = VW'(req_item.pixel_index);
                     wdata_in = {req_item.red, req_item.green, req_item.blue};
                     state_in = elbt_pkg::ST_WRITE;
                  end
                  elbt_pkg::OP_EMIT: state_in = elbt_pkg::ST_SETUP;
                  default: ;
               endcase
            end
         end
         elbt_pkg::ST_WRITE: begin
            if (addr_vld) begin
               state_in = elbt_pkg::ST_IDLE;
            end
         end
         elbt_pkg::ST_SETUP: begin
            dmax_in        = 16'(width_ff) * 16'(half_h_ff);
            x_in           = pos_x;
            row_in         = 7'(pos_row);
            strip_row_in   = next_row;
            column_step_in = next_col;
            frame_end_in   = next_fend;
            hdr_cnt_in     = 2'd0;
            issue_cnt_in   = '0;
            collect_cnt_in = '0;
            state_in = pos_header ? elbt_pkg::ST_HEADER : elbt_pkg::ST_GATHER;
         end
         elbt_pkg::ST_HEADER: begin
            rsp_strobe_in = 1'b1;
            rsp_item_in.last_of_run = 1'b0;
            rsp_item_in.frame_done  = 1'b0;
            if (hdr_cnt_ff == 2'd0) begin
               rsp_item_in.out_byte = elbt_pkg::SYNC_CHAR;
            end else if (hdr_cnt_ff == 2'd1) begin
               rsp_item_in.out_byte = sync_delay_ff[7:0];
            end else begin
               rsp_item_in.out_byte = sync_delay_ff[15:8];
            end
            hdr_cnt_in = hdr_cnt_ff + 2'd1;
            if (hdr_cnt_ff == 2'd2) begin
               state_in = elbt_pkg::ST_GATHER;
            end
         end
         elbt_pkg::ST_GATHER: begin
            if (issue_cnt_ff != CNT_W'(PINS)) begin
               va_in        = 1'b1;
               issue_cnt_in = issue_cnt_ff + 1'b1;
               row_in       = row_ff + 7'(spp_ff);
            end
            if (rvalid_ff) begin
               collect_cnt_in = collect_cnt_ff + 1'b1;
               if (collect_cnt_ff == CNT_W'(PINS - 1)) begin
                  state_in = elbt_pkg::ST_GAMMA;
                  gpin_in  = '0;
                  gcomp_in = elbt_pkg::COMP_RED;
                  gdone_in = 1'b0;
               end
            end
         end
         elbt_pkg::ST_GAMMA: begin
            if (!gdone_ff) begin
               gv_in = 1'b1;
               if (gcomp_ff == elbt_pkg::COMP_BLUE) begin
                  gcomp_in = elbt_pkg::COMP_RED;
                  if (gpin_ff == PIN_W'(PINS - 1)) begin
                     gdone_in = 1'b1;
                  end else begin
                     gpin_in = gpin_ff + 1'b1;
                  end
               end else begin
                  gcomp_in = gcomp_ff + 2'd1;
               end
            end
            if (gv_ff && (gtpin_ff == PIN_W'(PINS - 1)) && (gtcomp_ff == elbt_pkg::COMP_BLUE)) begin
               state_in    = elbt_pkg::ST_SEND;
               send_cnt_in = '0;
            end
         end
         elbt_pkg::ST_SEND: begin
            rsp_strobe_in = 1'b1;
            for (int i = 0; i < PINS; i++) begin
               rsp_item_in.out_byte[i] = grb_ff[i][GW-1];
            end
            rsp_item_in.last_of_run = (send_cnt_ff == BIT_W'(GW - 1));
            rsp_item_in.frame_done  = (send_cnt_ff == BIT_W'(GW - 1)) && frame_end_ff;
            send_cnt_in = send_cnt_ff + 1'b1;
            if (send_cnt_ff == BIT_W'(GW - 1)) begin
               state_in = elbt_pkg::ST_IDLE;
            end
         end
         default: state_in = elbt_pkg::ST_IDLE;
      endcase
   end

   // pixel collection, gamma lookups and transpose shift
   always_comb begin
      for (int i = 0; i < PINS; i++) begin
         pix_sr_in[i] = pix_sr_ff[i];
         grb_in[i]    = grb_ff[i];
      end
      if (rvalid_ff) begin
         for (int i = 0; i < PINS - 1; i++) begin
            pix_sr_in[i] = pix_sr_ff[i+1];
         end
         pix_sr_in[PINS-1] = pm_rdata;
      end
      if (gv_ff) begin
         case (gtcomp_ff)
            elbt_pkg::COMP_GREEN: grb_in[gtpin_ff][23:16] = gm_rdata;
            elbt_pkg::COMP_RED:   grb_in[gtpin_ff][15:8]  = gm_rdata;
            elbt_pkg::COMP_BLUE:  grb_in[gtpin_ff][7:0]   = gm_rdata;
            default: ;
         endcase
      end
      if (state_ff == elbt_pkg::ST_SEND) begin
         for (int i = 0; i < PINS; i++) begin
            grb_in[i] = {grb_ff[i][GW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      gsel = pix_sr_ff[gpin_ff];
      case (gcomp_ff)
         elbt_pkg::COMP_RED:   gm_raddr = gsel[23:16];
         elbt_pkg::COMP_GREEN: gm_raddr = gsel[15:8];
         elbt_pkg::COMP_BLUE:  gm_raddr = gsel[7:0];
         default:              gm_raddr = gsel[7:0];
      endcase
   end

   assign gm_we = accept && (req_item.operation == elbt_pkg::OP_WRITE_GAMMA);
   assign pm_we = addr_vld && (state_ff == elbt_pkg::ST_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= elbt_pkg::ST_IDLE;
         strip_length_ff <= 11'd8;
         led_height_ff   <= 7'd8;
         serp_ff         <= 1'b1;
         sync_delay_ff   <= 16'd25000;
         strip_row_ff    <= 3'd0;
         column_step_ff  <= 10'd0;
         hdr_cnt_ff      <= 2'd0;
         issue_cnt_ff    <= '0;
         collect_cnt_ff  <= '0;
         gdone_ff        <= 1'b0;
         gpin_ff         <= '0;
         gcomp_ff        <= elbt_pkg::COMP_RED;
         send_cnt_ff     <= '0;
         va_ff           <= 1'b0;
         areq_ff         <= '0;
         rvalid_ff       <= 1'b0;
         gv_ff           <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
         frame_end_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         strip_length_ff <= strip_length_in;
         led_height_ff   <= led_height_in;
         serp_ff         <= serp_in;
         sync_delay_ff   <= sync_delay_in;
         strip_row_ff    <= strip_row_in;
         column_step_ff  <= column_step_in;
         hdr_cnt_ff      <= hdr_cnt_in;
         issue_cnt_ff    <= issue_cnt_in;
         collect_cnt_ff  <= collect_cnt_in;
         gdone_ff        <= gdone_in;
         gpin_ff         <= gpin_in;
         gcomp_ff        <= gcomp_in;
         send_cnt_ff     <= send_cnt_in;
         va_ff           <= va_in;
         areq_ff         <= areq_in;
         rvalid_ff       <= rvalid_in;
         gv_ff           <= gv_in;
         rsp_strobe_ff   <= rsp_strobe_in;
         frame_end_ff    <= frame_end_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff    <= width_in;
      spp_ff      <= spp_in;
      half_h_ff   <= half_h_in;
      dmax_ff     <= dmax_in;
      x_ff        <= x_in;
      row_ff      <= row_in;
      idx_a_ff    <= idx_a_in;
      wdata_ff    <= wdata_in;
      gtpin_ff    <= gtpin_in;
      gtcomp_ff   <= gtcomp_in;
      rsp_item_ff <= rsp_item_in;
      for (int i = 0; i < PINS; i++) begin
         pix_sr_ff[i] <= pix_sr_in[i];
         grb_ff[i]    <= grb_in[i];
      end
   end

   elbt_addr_unit #(
      .PIXEL_DEPTH (PIXEL_DEPTH)
   ) u_addr (
      .clock    (clock),
      .reset    (reset),
      .areq     (areq_ff),
      .addr_vld (addr_vld),
      .addr     (pm_addr)
   );

   elbt_pixel_mem #(
      .PIXEL_DEPTH (PIXEL_DEPTH)
   ) u_pixel_mem (
      .clock (clock),
      .we    (pm_we),
      .addr  (pm_addr),
      .wdata (wdata_ff),
      .rdata (pm_rdata)
   );

   elbt_gamma_mem u_gamma_mem (
      .clock (clock),
      .reset (reset),
      .we    (gm_we),
      .waddr (req_item.gamma_index),
      .wdata (req_item.gamma_value),
      .raddr (gm_raddr),
      .rdata (gm_rdata)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

`default_nettype wire

### design/elbt_addr_unit.sv
// pixel address unit: panel base plus value modulo half the store, three stages
`default_nettype none

module elbt_addr_unit #(
   parameter int PIXEL_DEPTH = elbt_pkg::PIXEL_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire elbt_pkg::addr_req_type     areq,
   output logic                            addr_vld,
   output logic [$clog2(PIXEL_DEPTH)-1:0]  addr
);

   localparam int VW       = elbt_pkg::VAL_W;
   localparam int AW       = $clog2(PIXEL_DEPTH);
   localparam int HALF     = PIXEL_DEPTH / 2;
   localparam int RECIP_SH = 32;
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam int PROD_W   = VW + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SH) + 64'(HALF) - 64'd1) / 64'(HALF);
   localparam logic [RECIP_W-1:0] RECIP  = RECIP_FULL[RECIP_W-1:0];
   localparam logic [VW-1:0]      HALF_V = VW'(HALF);
   localparam logic [AW-1:0]      HALF_A = AW'(HALF);

   logic              s1_vld_ff, s1_vld_in;
   logic              s1_panel_ff, s1_panel_in;
   logic [VW-1:0]     s1_val_ff, s1_val_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              s2_vld_ff, s2_vld_in;
   logic              s2_panel_ff, s2_panel_in;
   logic [VW-1:0]     s2_val_ff, s2_val_in;
   logic [VW-1:0]     qh_ff, qh_in;
   logic              s3_vld_ff, s3_vld_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [VW-1:0]     quot;
   logic [2*VW-1:0]   qh_full;
   logic [VW-1:0]     rem;

   always_comb begin
      s1_vld_in   = areq.valid;
      s1_panel_in = areq.panel;
      s1_val_in   = areq.value;
      prod_in     = PROD_W'(areq.value) * PROD_W'(RECIP);

      quot        = prod_ff[RECIP_SH +: VW];
      qh_full     = quot * HALF_V;
      s2_vld_in   = s1_vld_ff;
      s2_panel_in = s1_panel_ff;
      s2_val_in   = s1_val_ff;
      qh_in       = qh_full[VW-1:0];

      rem       = s2_val_ff - qh_ff;
      s3_vld_in = s2_vld_ff;
      addr_in   = s2_panel_ff ? HALF_A + AW'(rem) : AW'(rem);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_panel_ff <= s1_panel_in;
      s1_val_ff   <= s1_val_in;
      prod_ff     <= prod_in;
      s2_panel_ff <= s2_panel_in;
      s2_val_ff   <= s2_val_in;
      qh_ff       <= qh_in;
      addr_ff     <= addr_in;
   end

   assign addr_vld = s3_vld_ff;
   assign addr     = addr_ff;

endmodule

`default_nettype wire

### design/elbt_pixel_mem.sv
// pixel store: single-port synchronous ram, registered read
`default_nettype none

module elbt_pixel_mem #(
   parameter int PIXEL_DEPTH = elbt_pkg::PIXEL_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           we,
   input  wire logic [$clog2(PIXEL_DEPTH)-1:0] addr,
   input  wire logic [elbt_pkg::GRB_W-1:0]     wdata,
   output logic [elbt_pkg::GRB_W-1:0]          rdata
);

   logic [elbt_pkg::GRB_W-1:0] pixel_mem [PIXEL_DEPTH];
   logic [elbt_pkg::GRB_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         pixel_mem[addr] <= wdata;
      end
      rdata_ff <= pixel_mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### design/elbt_gamma_mem.sv
// gamma table: 256 x 8 ram with valid bits, unwritten entries read as identity
`default_nettype none

module elbt_gamma_mem (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       we,
   input  wire logic [7:0] waddr,
   input  wire logic [7:0] wdata,
   input  wire logic [7:0] raddr,
   output logic [7:0]      rdata
);

   logic [7:0]   gamma_mem [256];
   logic [255:0] vld_ff, vld_in;
   logic [7:0]   rd_data_ff;
   logic         rd_vld_ff;
   logic [7:0]   rd_idx_ff;

   always_comb begin
      vld_in = vld_ff;
      if (we) begin
         vld_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         gamma_mem[waddr] <= wdata;
      end
      rd_data_ff <= gamma_mem[raddr];
      rd_vld_ff  <= vld_ff[raddr];
      rd_idx_ff  <= raddr;
   end

   assign rdata = rd_vld_ff ? rd_data_ff : rd_idx_ff;

endmodule

`default_nettype wire

### design/elbt_checker.sv
// port-level checks of the transposer top level and their bind
`default_nettype none

module elbt_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire elbt_pkg::req_type req_item,
   input wire logic              rsp_strobe,
   input wire elbt_pkg::rsp_type rsp_item,
   input wire logic              csr_valid,
   input wire logic              csr_ready,
   input wire logic [1:0]        csr_index,
   input wire logic [15:0]       csr_wdata
);

   // no result in the cycle right after an item is taken
   a_quiet_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("result right after item acceptance");

   a_frame_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.frame_done) |-> rsp_item.last_of_run)
      else $error("frame_done without last_of_run");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last_of_run) |=> !rsp_strobe)
      else $error("result after last byte of item");

   // busy only rises from an accepted item
   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without start");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result while block was idle");

endmodule

bind eight_lane_led_bit_transposer elbt_checker u_elbt_checker (.*);

`default_nettype wire
